FILE: src/tlvp_pkg.sv
// Types and codes shared by the type-length-value message parser.
// Holds the parser state record, the result record and the byte codes.
// No dependencies.
package tlvp_pkg;

   localparam int MAX_RESULTS = 3;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_RECHDR,
      PH_VALUE,
      PH_STOP
   } phase_type;

   // result kinds
   localparam logic [1:0] OUT_VALUE   = 2'd0;
   localparam logic [1:0] OUT_RECORD  = 2'd1;
   localparam logic [1:0] OUT_SUMMARY = 2'd2;

   // record kinds
   localparam logic [1:0] REC_NAME    = 2'd0;
   localparam logic [1:0] REC_PORT    = 2'd1;
   localparam logic [1:0] REC_SOURCE  = 2'd2;
   localparam logic [1:0] REC_UNKNOWN = 2'd3;

   // summary status
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_SHORT   = 2'd1;
   localparam logic [1:0] ST_BAD_CMD = 2'd2;

   // byte codes on the wire
   localparam logic [7:0] CMD_OPEN    = 8'h01;
   localparam logic [7:0] TYPE_NAME   = 8'h01;
   localparam logic [7:0] TYPE_PORT   = 8'h02;
   localparam logic [7:0] TYPE_SOURCE = 8'h03;

   localparam logic [16:0] POS_MAX = 17'h1FFFF;

   typedef struct packed {
      logic [16:0] byte_pos;
      logic [15:0] msg_size;
      logic        cmd_good;
      phase_type   phase;
      logic [1:0]  rec_kind;
      logic [15:0] rec_len;
      logic [15:0] bytes_left;
      logic [1:0]  hdr_idx;
      logic [15:0] port_holding;
      logic        port_found;
      logic [1:0]  port_taken;
      logic [15:0] port_committed;
   } state_type;

   // all zero; PH_HEADER encodes as zero
   localparam state_type STATE_RESET = '0;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [1:0]  record_kind;
      logic [7:0]  value_byte;
      logic [1:0]  parse_status;
      logic        tail_cut_short;
      logic [15:0] port_number;
      logic        port_seen;
   } result_type;

endpackage

FILE: src/tlvp_step.sv
// Next-state and result logic of the parser for one message byte.
// Purely combinational; the caller holds the state register.
// Depends on tlvp_pkg.
module tlvp_step (
   input  tlvp_pkg::state_type                          state_cur,
   input  logic [7:0]                                   data_byte,
   input  logic                                         end_of_buffer,
   output tlvp_pkg::state_type                          state_nxt,
   output tlvp_pkg::result_type [tlvp_pkg::MAX_RESULTS-1:0] res,
   output logic [1:0]                                   res_count
);
   import tlvp_pkg::*;

   state_type  nx;
   result_type val_res;
   result_type fin_res;
   result_type sum_res;
   logic       emit_val;
   logic       emit_fin;
   logic       do_finish;
   logic [16:0] p;

   assign p = state_cur.byte_pos;

   always_comb begin
      nx        = state_cur;
      emit_val  = 1'b0;
      emit_fin  = 1'b0;
      do_finish = 1'b0;
      val_res   = '0;
      fin_res   = '0;
      sum_res   = '0;

      case (state_cur.phase)
         PH_HEADER: begin
            if (p == 17'd0) begin
               nx.msg_size = {data_byte, 8'h00};
            end else if (p == 17'd1) begin
               nx.msg_size[7:0] = data_byte;
            end else if (p == 17'd3) begin
               nx.cmd_good = (data_byte == CMD_OPEN);
               nx.phase    = (data_byte == CMD_OPEN) ? PH_RECHDR : PH_STOP;
               nx.hdr_idx  = 2'd0;
            end
         end
         PH_RECHDR: begin
            // record header must fit inside the message size
            if (state_cur.hdr_idx == 2'd0 &&
                ({1'b0, p} + 18'd4 > {2'b00, state_cur.msg_size})) begin
               nx.phase = PH_STOP;
            end else begin
               case (state_cur.hdr_idx)
                  2'd0: nx.rec_kind = (data_byte == 8'h00) ? REC_NAME : REC_UNKNOWN;
                  2'd1: begin
                     if (state_cur.rec_kind == REC_NAME) begin
                        if (data_byte == TYPE_NAME)        nx.rec_kind = REC_NAME;
                        else if (data_byte == TYPE_PORT)   nx.rec_kind = REC_PORT;
                        else if (data_byte == TYPE_SOURCE) nx.rec_kind = REC_SOURCE;
                        else                               nx.rec_kind = REC_UNKNOWN;
                     end
                  end
                  2'd2: nx.rec_len = {data_byte, 8'h00};
                  default: nx.rec_len = {state_cur.rec_len[15:8], data_byte};
               endcase
               nx.hdr_idx = state_cur.hdr_idx + 2'd1;
               if (state_cur.hdr_idx == 2'd3) begin
                  // value must end inside the message size
                  if ({1'b0, p} + 18'd1 + {2'b00, nx.rec_len} >
                      {2'b00, state_cur.msg_size}) begin
                     nx.phase = PH_STOP;
                  end else if (nx.rec_len == 16'd0) begin
                     nx.port_taken = 2'd0;
                     do_finish     = 1'b1;
                  end else begin
                     nx.phase        = PH_VALUE;
                     nx.bytes_left   = nx.rec_len;
                     nx.port_taken   = 2'd0;
                     nx.port_holding = 16'd0;
                  end
               end
            end
         end
         PH_VALUE: begin
            if (state_cur.rec_kind == REC_NAME || state_cur.rec_kind == REC_SOURCE) begin
               emit_val               = 1'b1;
               val_res.out_kind       = OUT_VALUE;
               val_res.record_kind    = state_cur.rec_kind;
               val_res.value_byte     = data_byte;
            end else if (state_cur.rec_kind == REC_PORT && state_cur.port_taken < 2'd2) begin
               nx.port_holding = {state_cur.port_holding[7:0], data_byte};
               nx.port_taken   = state_cur.port_taken + 2'd1;
            end
            nx.bytes_left = state_cur.bytes_left - 16'd1;
            if (nx.bytes_left == 16'd0) begin
               do_finish = 1'b1;
            end
         end
         default: begin
            // stopped: ignore the byte
         end
      endcase

      if (do_finish) begin
         // commit the port only when two bytes of it arrived
         if (nx.rec_kind == REC_PORT && nx.port_taken == 2'd2) begin
            nx.port_committed = nx.port_holding;
            nx.port_found     = 1'b1;
         end
         if (nx.rec_kind != REC_UNKNOWN) begin
            emit_fin            = 1'b1;
            fin_res.out_kind    = OUT_RECORD;
            fin_res.record_kind = nx.rec_kind;
         end
         nx.phase   = PH_RECHDR;
         nx.hdr_idx = 2'd0;
      end

      if (p != POS_MAX) begin
         nx.byte_pos = p + 17'd1;
      end

      if (end_of_buffer) begin
         sum_res.out_kind = OUT_SUMMARY;
         if (nx.byte_pos < 17'd4) begin
            sum_res.parse_status = ST_SHORT;
         end else if (!nx.cmd_good) begin
            sum_res.parse_status = ST_BAD_CMD;
         end else begin
            sum_res.parse_status   = ST_OK;
            sum_res.tail_cut_short = (nx.phase == PH_VALUE);
            sum_res.port_number    = nx.port_committed;
            sum_res.port_seen      = nx.port_found;
         end
         nx = STATE_RESET;
      end
   end

   // pack the results in order: value byte, record finished, summary
   always_comb begin
      res       = '0;
      res_count = 2'd0;
      if (emit_val) begin
         res[res_count] = val_res;
         res_count      = res_count + 2'd1;
      end
      if (emit_fin) begin
         res[res_count] = fin_res;
         res_count      = res_count + 2'd1;
      end
      if (end_of_buffer) begin
         res[res_count] = sum_res;
         res_count      = res_count + 2'd1;
      end
   end

   assign state_nxt = nx;

endmodule

FILE: src/tlv_message_parser.sv
// Top level of the type-length-value message parser.
// Input register, parser state register and result group buffer.
// Depends on tlvp_pkg and tlvp_step.
//
// Usage:
//   req_*  carries one buffer byte per transfer in req_tdata[7:0]; req_tlast
//          marks the final byte of the buffer. The next byte after it starts
//          a new message.
//   rsp_*  carries results: value bytes of name and source id records, a
//          record-finished marker for known records, and on the buffer's
//          last byte a summary with status, port and cut-short flag.
//          rsp_tlast marks the final result caused by one input byte.
// Path: a byte waits in the input register, its results are computed from it
//   and offered from the result register.
// Throughput: one byte per cycle while each byte yields at most one result and
//   rsp_tready is high; a byte yielding several results holds the result port
//   until all have transferred, and the input register waits behind it.
// Reset: synchronous, active high; clears the input register, the result
//   buffer and all parser state, so the next byte is a header byte.
// Stall: when rsp_tready is low the pending results hold, one byte waits in
//   the input register and req_tready drops; nothing is lost.
module tlv_message_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] value_byte, [9:8] parse_status,
                                    // [10] tail_cut_short, [26:11] port_number,
                                    // [27] port_seen, [31:28] zero
   output logic [3:0]  rsp_tuser,   // [1:0] out_kind, [3:2] record_kind
   output logic        rsp_tlast    // last_of_run
);
   import tlvp_pkg::*;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eob_ff;

   // parser state
   state_type  state_ff;
   state_type  state_in;

   // results of the byte being delivered
   result_type [MAX_RESULTS-1:0] grp_ff;
   result_type [MAX_RESULTS-1:0] grp_in;
   logic [1:0] grp_cnt_ff;
   logic [1:0] grp_idx_ff;
   logic [1:0] grp_cnt_in;

   logic       rsp_xfer;
   logic       grp_last;
   logic       grp_free;
   logic       consume;
   result_type cur_res;

   tlvp_step u_step (
      .state_cur     (state_ff),
      .data_byte     (in_byte_ff),
      .end_of_buffer (in_eob_ff),
      .state_nxt     (state_in),
      .res           (grp_in),
      .res_count     (grp_cnt_in)
   );

   assign rsp_tvalid = (grp_cnt_ff != 2'd0);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign grp_last   = (grp_idx_ff == grp_cnt_ff - 2'd1);
   // buffer empty, or its final result leaves in this cycle
   assign grp_free   = (grp_cnt_ff == 2'd0) || (rsp_xfer && grp_last);
   assign consume    = in_valid_ff && grp_free;
   assign req_tready = !in_valid_ff || consume;

   // input register: take a byte when empty or when the held one moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_eob_ff  <= req_tlast;
      end
   end

   // advance parser state once per consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (consume) begin
         state_ff <= state_in;
      end
   end

   // load a new result group or step through the pending one
   always_ff @(posedge clock) begin
      if (reset) begin
         grp_cnt_ff <= 2'd0;
         grp_idx_ff <= 2'd0;
      end else if (consume) begin
         grp_cnt_ff <= grp_cnt_in;
         grp_idx_ff <= 2'd0;
      end else if (rsp_xfer) begin
         if (grp_last) begin
            grp_cnt_ff <= 2'd0;
            grp_idx_ff <= 2'd0;
         end else begin
            grp_idx_ff <= grp_idx_ff + 2'd1;
         end
      end
      if (consume) begin
         grp_ff <= grp_in;
      end
   end

   assign cur_res   = grp_ff[grp_idx_ff];
   assign rsp_tdata = {4'b0000, cur_res.port_seen, cur_res.port_number,
                       cur_res.tail_cut_short, cur_res.parse_status,
                       cur_res.value_byte};
   assign rsp_tuser = {cur_res.record_kind, cur_res.out_kind};
   assign rsp_tlast = grp_last;

endmodule

FILE: test/tlv_message_parser_tb.sv
// Self-checking testbench for the type-length-value message parser.
// Streams buffer bytes into req_*, predicts every rsp_* transfer and compares each field.
// Depends on tlvp_pkg and tlv_message_parser.
module tlv_message_parser_tb;
   import tlvp_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 6;
   localparam int IDLE_LIMIT   = 2000;   // far above the longest receiver hold
   localparam int RANDOM_ITEMS = 200;
   localparam int HOLD_CYCLES  = 80;
   localparam int TAIL_CYCLES  = 8;
   localparam int DIR_ROWS     = 25;
   localparam int MAX_REPORTS  = 40;

   // one predicted rsp transfer: result fields plus rsp_tlast
   typedef struct packed {
      result_type res;
      logic       is_last;
   } parser_out_type;

   // directed row: byte, end-of-buffer flag and, on summary rows, the typed-in
   // status and port that the predictor must agree with
   typedef struct packed {
      logic [7:0]  data;
      logic        eob;
      logic        chk;
      logic [1:0]  status;
      logic [15:0] port;
   } dir_row_type;

   dir_row_type dir_table [DIR_ROWS] = '{
      // single-byte buffer: too short for a header
      '{8'h00, 1'b1, 1'b1, ST_SHORT,   16'h0000},
      // full header with a wrong command, then an ignored byte
      '{8'h00, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h08, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h00, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h02, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h55, 1'b1, 1'b1, ST_BAD_CMD, 16'h0000},
      // size 19: name record of one byte, port record FFFF, empty source record
      '{8'h00, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h13, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'hFF, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h01, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h00, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h01, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h00, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h01, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'hFF, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h00, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h02, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h00, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h02, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'hFF, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'hFF, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h00, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h03, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h00, 1'b0, 1'b0, ST_OK,      16'h0000},
      '{8'h00, 1'b1, 1'b1, ST_OK,      16'hFFFF}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tlast  = 1'b0;    // end_of_buffer
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [7:0] value_byte, [9:8] parse_status,
                                      // [10] tail_cut_short, [26:11] port_number,
                                      // [27] port_seen, [31:28] zero
   logic [3:0]  rsp_tuser;            // [1:0] out_kind, [3:2] record_kind
   logic        rsp_tlast;            // last_of_run

   // parser state mirrored by the predictor
   logic [16:0] pos_count;
   logic [15:0] size_field;
   logic        cmd_ok;
   phase_type   parse_phase;
   logic [1:0]  rec_kind;
   logic [15:0] rec_len;
   logic [15:0] value_left;
   logic [1:0]  hdr_idx;
   logic [15:0] port_value;
   logic [15:0] port_last;
   logic        port_got;
   logic [1:0]  port_cnt;

   parser_out_type run_buf [MAX_RESULTS];
   int             run_len;
   parser_out_type pending_results [$];

   logic [7:0]  msg_bytes [$];
   int          errors          = 0;
   int          results_checked = 0;
   int          bytes_sent      = 0;
   int          burst_left      = 0;
   int          idle_cycles     = 0;
   bit          hold_request    = 1'b0;

   tlv_message_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      end
   endfunction

   // Return the predictor to the state after reset.
   function automatic void clear_parser();
      pos_count   = '0;
      size_field  = '0;
      cmd_ok      = 1'b0;
      parse_phase = PH_HEADER;
      rec_kind    = REC_NAME;
      rec_len     = '0;
      value_left  = '0;
      hdr_idx     = '0;
      port_value  = '0;
      port_last   = '0;
      port_got    = 1'b0;
      port_cnt    = '0;
   endfunction

   function automatic void add_result(logic [1:0] okind, logic [1:0] rkind, logic [7:0] vbyte,
                                      logic [1:0] status, logic tail, logic [15:0] port,
                                      logic seen);
      parser_out_type e;
      e = '0;
      e.res.out_kind       = okind;
      e.res.record_kind    = rkind;
      e.res.value_byte     = vbyte;
      e.res.parse_status   = status;
      e.res.tail_cut_short = tail;
      e.res.port_number    = port;
      e.res.port_seen      = seen;
      run_buf[run_len] = e;
      run_len++;
   endfunction

   // Close the record in progress: commit a two-byte port, mark known kinds.
   function automatic void close_record();
      if (rec_kind == REC_PORT && port_cnt == 2'd2) begin
         port_last = port_value;
         port_got  = 1'b1;
      end
      if (rec_kind != REC_UNKNOWN)
         add_result(OUT_RECORD, rec_kind, 8'h00, ST_OK, 1'b0, 16'h0000, 1'b0);
      parse_phase = PH_RECHDR;
      hdr_idx     = '0;
   endfunction

   // Advance the predicted parser by one accepted byte and queue its results.
   function automatic void parse_byte(logic [7:0] b, logic eob);
      logic [16:0] p;
      logic [1:0]  st;
      p = pos_count;
      run_len = 0;
      case (parse_phase)
         PH_HEADER: begin
            if (p == 17'd0) begin
               size_field = {b, 8'h00};
            end else if (p == 17'd1) begin
               size_field[7:0] = b;
            end else if (p == 17'd3) begin
               cmd_ok      = (b == CMD_OPEN);
               parse_phase = cmd_ok ? PH_RECHDR : PH_STOP;
               hdr_idx     = '0;
            end
         end
         PH_RECHDR: begin
            if (hdr_idx == 2'd0 && int'(p) + 4 > int'(size_field)) begin
               parse_phase = PH_STOP;
            end else begin
               case (hdr_idx)
                  2'd0: rec_kind = (b == 8'h00) ? REC_NAME : REC_UNKNOWN;
                  2'd1: begin
                     if (rec_kind == REC_NAME) begin
                        if (b == TYPE_NAME)        rec_kind = REC_NAME;
                        else if (b == TYPE_PORT)   rec_kind = REC_PORT;
                        else if (b == TYPE_SOURCE) rec_kind = REC_SOURCE;
                        else                       rec_kind = REC_UNKNOWN;
                     end
                  end
                  2'd2: rec_len = {b, 8'h00};
                  default: rec_len[7:0] = b;
               endcase
               hdr_idx = hdr_idx + 2'd1;
               if (hdr_idx == 2'd0) begin
                  if (int'(p) + 1 + int'(rec_len) > int'(size_field)) begin
                     parse_phase = PH_STOP;
                  end else if (rec_len == 16'd0) begin
                     port_cnt = '0;
                     close_record();
                  end else begin
                     parse_phase = PH_VALUE;
                     value_left  = rec_len;
                     port_cnt    = '0;
                     port_value  = '0;
                  end
               end
            end
         end
         PH_VALUE: begin
            if (rec_kind == REC_NAME || rec_kind == REC_SOURCE) begin
               add_result(OUT_VALUE, rec_kind, b, ST_OK, 1'b0, 16'h0000, 1'b0);
            end else if (rec_kind == REC_PORT && port_cnt < 2'd2) begin
               port_value = {port_value[7:0], b};
               port_cnt   = port_cnt + 2'd1;
            end
            value_left = value_left - 16'd1;
            if (value_left == 16'd0)
               close_record();
         end
         default: ;
      endcase
      if (pos_count != POS_MAX)
         pos_count = pos_count + 17'd1;
      if (eob) begin
         if (pos_count < 17'd4) st = ST_SHORT;
         else if (!cmd_ok)      st = ST_BAD_CMD;
         else                   st = ST_OK;
         add_result(OUT_SUMMARY, REC_NAME, 8'h00, st,
                    (st == ST_OK && parse_phase == PH_VALUE),
                    (st == ST_OK) ? port_last : 16'h0000,
                    (st == ST_OK) ? port_got : 1'b0);
         clear_parser();
      end
      if (run_len > 0)
         run_buf[run_len - 1].is_last = 1'b1;
      for (int k = 0; k < run_len; k++)
         pending_results.push_back(run_buf[k]);
   endfunction

   // Offer one byte; gaps open only between bursts, so valid stays high inside a burst.
   task automatic send_byte(input logic [7:0] b, input logic eob);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eob;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_byte(b, eob);
      burst_left--;
      bytes_sent++;
   endtask

   // Drop valid and hold until every predicted result has been seen.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Build one random buffer into msg_bytes: a short noise buffer, or a message with
   // random records that may get a bent size, a cut tail, trailing bytes, a bad
   // length or a wrong command.
   task automatic build_message(input bit long_name);
      int sel;
      int nrec;
      int len;
      int size;
      int k;
      logic [7:0] thi;
      logic [7:0] tlo;
      logic [7:0] body [$];
      msg_bytes.delete();
      if (!long_name && $urandom_range(0, 99) < 20) begin
         len = $urandom_range(1, 7);
         repeat (len) msg_bytes.push_back(8'($urandom));
         return;
      end
      nrec = long_name ? 1 : $urandom_range(0, 3);
      repeat (nrec) begin
         sel = long_name ? 0 : $urandom_range(0, 9);
         thi = 8'h00;
         if (sel < 3) begin
            tlo = TYPE_NAME;
            len = long_name ? 16 : $urandom_range(0, 6);
         end else if (sel < 6) begin
            tlo = TYPE_PORT;
            len = ($urandom_range(0, 3) != 0) ? 2 : $urandom_range(0, 4);
         end else if (sel < 8) begin
            tlo = TYPE_SOURCE;
            len = $urandom_range(0, 6);
         end else begin
            thi = 8'($urandom);
            tlo = 8'($urandom);
            len = $urandom_range(0, 4);
         end
         body.push_back(thi);
         body.push_back(tlo);
         body.push_back(8'(len >> 8));
         body.push_back(8'(len));
         repeat (len) body.push_back(8'($urandom));
      end
      size = 4 + body.size();
      sel = long_name ? 11 : $urandom_range(0, 11);
      case (sel)
         0: size = size - $urandom_range(1, 3);          // overrun or header past size
         1: begin                                        // buffer ends inside the body
            k = $urandom_range(1, 3);
            while (k > 0 && body.size() > 0) begin
               body.delete(body.size() - 1);
               k--;
            end
         end
         2: repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));  // beyond size
         3: size = size + $urandom_range(1, 6);          // size promises more bytes
         4: size = $urandom_range(0, 65535);
         5: if (body.size() >= 4) body[2] = 8'($urandom); // large record length
         default: ;
      endcase
      msg_bytes.push_back(8'(size >> 8));
      msg_bytes.push_back(8'(size));
      msg_bytes.push_back(8'($urandom));                 // version, ignored
      msg_bytes.push_back((!long_name && $urandom_range(0, 19) == 0) ? 8'($urandom)
                                                                       : CMD_OPEN);
      foreach (body[j]) msg_bytes.push_back(body[j]);
   endtask

   // Receiver: switch between random stall patterns; on request hold off for a
   // long stretch so the parser fills up and stalls its input.
   initial begin
      int mode;
      int span;
      int tick;
      mode = 0;
      span = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 80);
         end
         span--;
         tick++;
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 9) != 0);
            default: rsp_tready <= ((tick % 7) < 4);
         endcase
      end
   end

   // Compare each rsp transfer with the oldest prediction.
   always @(posedge clock) begin
      parser_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: result with no expectation, expected none actual tuser %0h tdata %0h",
                        $time, rsp_tuser, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            check_field("out_kind",       want.res.out_kind,       rsp_tuser[1:0]);
            check_field("record_kind",    want.res.record_kind,    rsp_tuser[3:2]);
            check_field("value_byte",     want.res.value_byte,     rsp_tdata[7:0]);
            check_field("parse_status",   want.res.parse_status,   rsp_tdata[9:8]);
            check_field("tail_cut_short", want.res.tail_cut_short, rsp_tdata[10]);
            check_field("port_number",    want.res.port_number,    rsp_tdata[26:11]);
            check_field("port_seen",      want.res.port_seen,      rsp_tdata[27]);
            check_field("tdata padding",  4'h0,                    rsp_tdata[31:28]);
            check_field("last_of_run",    want.is_last,            rsp_tlast);
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending_results.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int m;
      int sent_random;
      clear_parser();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; cross-check the typed-in summaries against the predictor
      for (int i = 0; i < DIR_ROWS; i++) begin
         send_byte(dir_table[i].data, dir_table[i].eob);
         if (dir_table[i].chk) begin
            check_field("table status", dir_table[i].status,
                        pending_results[$].res.parse_status);
            check_field("table port", dir_table[i].port, pending_results[$].res.port_number);
         end
      end

      // random buffers; one long name record meets a long receiver hold, and
      // once the sender pauses until everything has drained
      m = 0;
      sent_random = 0;
      while (sent_random < RANDOM_ITEMS) begin
         if (m == 2)
            hold_request = 1'b1;
         if (m == 4)
            wait_drained();
         build_message(m == 2);
         foreach (msg_bytes[j])
            send_byte(msg_bytes[j], j == msg_bytes.size() - 1);
         sent_random += msg_bytes.size();
         m++;
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d table rows and %0d random buffers, with a long receiver hold.",
               DIR_ROWS, m);
      $display("Sent %0d bytes and checked %0d results.", bytes_sent, results_checked);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: tlv_message_parser.f
src/tlvp_pkg.sv
src/tlvp_step.sv
src/tlv_message_parser.sv
test/tlv_message_parser_tb.sv
